// File: src/keypad_four_function_calculator_defines.svh
// Assertion macros shared by the calculator checker.
`ifndef KEYPAD_FOUR_FUNCTION_CALCULATOR_DEFINES_SVH
`define KEYPAD_FOUR_FUNCTION_CALCULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/kfc_pkg.sv
// Shared widths, key codes and operator codes of the keypad calculator.
`timescale 1ns / 1ps
`default_nettype none

package kfc_pkg;

  localparam int VALUE_W    = 64;  // Q47.16 result width
  localparam int ENTRY_W    = 30;  // holds nine decimal digits
  localparam int MAX_DIGITS = 9;
  localparam int FRAC_BITS  = 16;
  localparam int COUNT_W    = 4;   // digit count, 0 to MAX_DIGITS
  localparam int STEP_W     = $clog2(VALUE_W);

  localparam int IN_DATA_W  = 8;   // digit and operator, padded to a byte
  localparam int IN_USER_W  = 2;   // key kind
  localparam int OUT_USER_W = 1;   // divide-by-zero flag

  localparam logic [1:0] KIND_DIGIT  = 2'd0;
  localparam logic [1:0] KIND_OPER   = 2'd1;
  localparam logic [1:0] KIND_EQUALS = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};

endpackage

`default_nettype wire

// File: src/keypad_four_function_calculator.sv
// Top level of the keypad four-function calculator with its serial multiply and divide.
//
// The block takes key transactions on the s_ channel and returns results on the m_ channel.
// s_tuser carries the key kind (digit, operator, equals, clear); s_tdata carries the digit
// value in bits 3:0 and the operator code in bits 5:4. A transaction on m_ carries the
// signed Q47.16 result in m_tdata and the divide-by-zero flag in m_tuser; only an equals
// key produces one.
// Digit, operator and clear keys are taken without leaving idle, and s_tready stays high.
// After an equals key s_tready drops while the result is formed. Add, subtract and a
// divide by zero go straight to the finish state, multiply first runs its serial state
// (one multiplier bit per cycle over the 30-bit entry) and divide its own serial state
// (one quotient bit per cycle over the 64-bit magnitude of the first operand). The next
// key is taken once the finish state has loaded the result into the output register.
// The output register parts the two sides: keys that give no result are still taken while
// a result waits on a stalled m_ channel, and a new result waits in the block until the
// output register is free, holding s_tready low meanwhile.
// A synchronous reset, like the clear key, returns the operands, the entry and the pending
// operator to zero and marks a fresh start; reset also drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module keypad_four_function_calculator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [kfc_pkg::IN_DATA_W-1:0]   s_tdata,   // digit[3:0], operator[5:4], zeros
  input  wire logic [kfc_pkg::IN_USER_W-1:0]   s_tuser,   // kind[1:0]
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [kfc_pkg::VALUE_W-1:0]          m_tdata,   // value[63:0]
  output logic [kfc_pkg::OUT_USER_W-1:0]       m_tuser    // div_by_zero[0]
);

  localparam int VW = kfc_pkg::VALUE_W;
  localparam int EW = kfc_pkg::ENTRY_W;
  localparam logic [kfc_pkg::STEP_W-1:0] MUL_LAST = kfc_pkg::STEP_W'(EW - 1);
  localparam logic [kfc_pkg::STEP_W-1:0] DIV_LAST = kfc_pkg::STEP_W'(VW - 1);
  localparam logic [kfc_pkg::COUNT_W-1:0] DIGIT_LIMIT =
    kfc_pkg::COUNT_W'(kfc_pkg::MAX_DIGITS);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MUL    = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;

  // Calculator state.
  logic [VW-1:0]                 first_operand;
  logic [EW-1:0]                 entry_value;
  logic [kfc_pkg::COUNT_W-1:0]   digit_count;
  logic                          fresh_start;
  logic [1:0]                    pending_op;
  logic [VW-1:0]                 last_result;

  // Arithmetic working registers.
  logic [VW-1:0]                 mag;       // magnitude of the first operand
  logic                          neg;       // sign of the first operand
  logic [VW-1:0]                 work_hi;   // product high part, or dividend/quotient
  logic [EW-1:0]                 work_lo;   // multiplier/product low part, or divisor
  logic [EW-1:0]                 rem;
  logic [kfc_pkg::STEP_W-1:0]    step;
  logic [VW-1:0]                 res;       // add or subtract result
  logic                          dz;

  // Input fields.
  logic [1:0] kind;
  logic [3:0] key_digit;
  logic [1:0] key_op;
  logic       in_fire;

  assign kind      = s_tuser;
  assign key_digit = s_tdata[3:0];
  assign key_op    = s_tdata[5:4];
  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;

  // The entry in fixed point; nine digits shifted by the fraction always fit.
  logic [VW-1:0] entry_fixed;
  assign entry_fixed = VW'({entry_value, {kfc_pkg::FRAC_BITS{1'b0}}});

  logic [EW-1:0] entry_times_ten;
  assign entry_times_ten = (entry_value << 3) + (entry_value << 1) + EW'(key_digit);

  logic [VW-1:0] sum_ab;
  logic [VW-1:0] diff_ab;
  logic [VW-1:0] add_sat;
  logic [VW-1:0] sub_sat;
  assign sum_ab  = first_operand + entry_fixed;
  assign diff_ab = first_operand - entry_fixed;
  assign add_sat = (!first_operand[VW-1] && sum_ab[VW-1]) ? kfc_pkg::MOST_POS : sum_ab;
  assign sub_sat = (first_operand[VW-1] && !diff_ab[VW-1]) ? kfc_pkg::MOST_NEG : diff_ab;

  // One multiplier bit per step: add the magnitude when the bit is set, then shift right.
  logic [VW:0] mul_sum;
  assign mul_sum = {1'b0, work_hi} + (work_lo[0] ? {1'b0, mag} : {(VW+1){1'b0}});

  // One quotient bit per step of restoring division.
  logic [EW:0] rem_shift;
  logic [EW:0] rem_diff;
  logic        rem_ge;
  assign rem_shift = {rem, work_hi[VW-1]};
  assign rem_diff  = rem_shift - {1'b0, work_lo};
  assign rem_ge    = (rem_shift >= {1'b0, work_lo});

  // Signed, saturated results at the end of the serial operations.
  logic          mul_over;
  logic [VW-1:0] mul_mag;
  logic [VW-1:0] mul_val;
  logic [VW-1:0] div_val;
  logic [VW-1:0] fin_val;
  assign mul_over = |work_hi[VW-1:VW-EW];
  assign mul_mag  = {work_hi[VW-EW-1:0], work_lo};

  always_comb begin
    if (neg) begin
      mul_val = (mul_over || (mul_mag > kfc_pkg::MOST_NEG)) ? kfc_pkg::MOST_NEG : -mul_mag;
    end else begin
      mul_val = (mul_over || mul_mag[VW-1]) ? kfc_pkg::MOST_POS : mul_mag;
    end
  end

  // The quotient never exceeds the magnitude, so only the sign is applied.
  assign div_val = neg ? -work_hi : work_hi;

  always_comb begin
    unique case (pending_op)
      kfc_pkg::OP_ADD, kfc_pkg::OP_SUB: fin_val = res;
      kfc_pkg::OP_MUL:                  fin_val = mul_val;
      default:                          fin_val = dz ? {VW{1'b0}} : div_val;
    endcase
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      first_operand <= '0;
      entry_value   <= '0;
      digit_count   <= '0;
      fresh_start   <= 1'b1;
      pending_op    <= kfc_pkg::OP_ADD;
      last_result   <= '0;
      step          <= '0;
      dz            <= 1'b0;
    end else begin
      // The finish state reloads the output register itself.
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (kind)
              kfc_pkg::KIND_DIGIT: begin
                if ((key_digit <= 4'd9) && (digit_count < DIGIT_LIMIT)) begin
                  entry_value <= entry_times_ten;
                  digit_count <= digit_count + 1'b1;
                end
              end
              kfc_pkg::KIND_OPER: begin
                first_operand <= fresh_start ? entry_fixed : last_result;
                fresh_start   <= 1'b0;
                pending_op    <= key_op;
                entry_value   <= '0;
                digit_count   <= '0;
              end
              kfc_pkg::KIND_EQUALS: begin
                entry_value <= '0;
                digit_count <= '0;
                neg         <= first_operand[VW-1];
                mag         <= first_operand[VW-1] ? -first_operand : first_operand;
                step        <= '0;
                dz          <= 1'b0;
                unique case (pending_op)
                  kfc_pkg::OP_ADD: begin
                    res   <= add_sat;
                    state <= ST_FINISH;
                  end
                  kfc_pkg::OP_SUB: begin
                    res   <= sub_sat;
                    state <= ST_FINISH;
                  end
                  kfc_pkg::OP_MUL: begin
                    work_hi <= '0;
                    work_lo <= entry_value;
                    state   <= ST_MUL;
                  end
                  default: begin
                    if (entry_value == '0) begin
                      dz          <= 1'b1;
                      fresh_start <= 1'b1;
                      state       <= ST_FINISH;
                    end else begin
                      work_hi <= first_operand[VW-1] ? -first_operand : first_operand;
                      work_lo <= entry_value;
                      rem     <= '0;
                      state   <= ST_DIV;
                    end
                  end
                endcase
              end
              default: begin
                first_operand <= '0;
                entry_value   <= '0;
                digit_count   <= '0;
                fresh_start   <= 1'b1;
                pending_op    <= kfc_pkg::OP_ADD;
                last_result   <= '0;
              end
            endcase
          end
        end
        ST_MUL: begin
          work_hi <= mul_sum[VW:1];
          work_lo <= {mul_sum[0], work_lo[EW-1:1]};
          step    <= step + 1'b1;
          if (step == MUL_LAST) begin
            state <= ST_FINISH;
          end
        end
        ST_DIV: begin
          rem     <= rem_ge ? rem_diff[EW-1:0] : rem_shift[EW-1:0];
          work_hi <= {work_hi[VW-2:0], rem_ge};
          step    <= step + 1'b1;
          if (step == DIV_LAST) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= fin_val;
            m_tuser  <= dz;
            if (!dz) begin
              last_result <= fin_val;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/kfc_checker.sv
// Port-level checker for the keypad calculator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "keypad_four_function_calculator_defines.svh"

module kfc_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic [kfc_pkg::IN_DATA_W-1:0]   s_tdata,
  input wire logic [kfc_pkg::IN_USER_W-1:0]   s_tuser,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [kfc_pkg::VALUE_W-1:0]     m_tdata,
  input wire logic [kfc_pkg::OUT_USER_W-1:0]  m_tuser
);

  logic key_fire;
  logic equals_fire;
  logic out_stall;
  logic dz_out;
  logic plain_fire;
  logic idle_equals;
  logic [kfc_pkg::VALUE_W+kfc_pkg::OUT_USER_W-1:0] out_word;
  assign key_fire    = s_tvalid && s_tready;
  assign equals_fire = key_fire && (s_tuser == kfc_pkg::KIND_EQUALS);
  assign out_stall   = m_tvalid && !m_tready;
  assign dz_out      = m_tvalid && m_tuser[0];
  assign plain_fire  = key_fire && !equals_fire && !m_tvalid;
  assign idle_equals = equals_fire && !m_tvalid;
  assign out_word    = {m_tdata, m_tuser};

  // A stalled result holds.
  `KFC_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_tvalid && $stable(out_word), "result not held")

  // A divide-by-zero error always reports a zero value.
  `KFC_ASSERT_NOW(a_dz_zero, clk, rst, dz_out, m_tdata == '0, "error value not zero")

  // Keys other than equals never produce a result.
  `KFC_ASSERT_NEXT(a_no_spurious, clk, rst, plain_fire, !m_tvalid, "result without equals key")

  // Equals makes the block busy until its result reaches the output register.
  `KFC_ASSERT_NEXT(a_equals_busy, clk, rst, equals_fire, !s_tready, "key taken while busy")

  // The result of an equals key never shows in the cycle right after it.
  `KFC_ASSERT_NEXT(a_busy_no_result, clk, rst, idle_equals, !m_tvalid, "result came too early")

endmodule

bind keypad_four_function_calculator kfc_checker u_kfc_checker (.*);

`default_nettype wire
